// ----- design/bezier_curve_point_eval_macros.svh -----
// assertion helpers used by bezier_curve_point_eval
`ifndef BEZIER_CURVE_POINT_EVAL_MACROS_SVH
`define BEZIER_CURVE_POINT_EVAL_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define BCPE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCPE_ASSERT(lbl, ante, cons, msg)
`define BCPE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/bcpe_pkg.sv -----
package bcpe_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    // curve parameter is unsigned q1.16, one is 65536
    localparam int         T_FRAC = 16;
    localparam int         T_HALF = 1 << (T_FRAC - 1);
    localparam logic [16:0] T_ONE = 17'd65536;

    // output coordinates carry eight fraction bits
    localparam int OUT_FRAC = 8;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PASS   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_SINGLE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

// ----- design/bezier_curve_point_eval.sv -----
// an evaluate with N stored points runs N-1 de casteljau passes of length N..2
// through a read/subtract/multiply/write pipe, one lerp a cycle within a pass, with
// a drain after each pass until its writes have landed; a single point is passed
// through, an empty store goes straight to the result, loads write the store directly
// one request at a time, x and y side by side; s_tready is low until the result loads
// rst_n clears control state asynchronously, store contents are unknown until loaded
`include "bezier_curve_point_eval_macros.svh"

module bezier_curve_point_eval #(
    parameter int MAX_POINTS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // point_x[15:0], point_y[31:16], curve_param[48:32]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // curve_x[23:0], curve_y[47:24]
    output logic [1:0]  m_tuser    // no_points[0], points_dropped[1]
);

    localparam int W     = 16 + FRAC_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int PW    = W + 19;
    localparam int SH    = FRAC_BITS - bcpe_pkg::OUT_FRAC;
    localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
    localparam logic [W-1:0] RND = (SH > 0) ? (W'(1) << SH_M1) : '0;

    bcpe_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [16:0]   t_reg, t_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          fp_reg, fp_next;
    logic          emp_reg, emp_next;
    logic          drop_reg, drop_next;

    // read pipe control
    logic          rdv_reg, rd0_reg, rdc_reg;
    logic [AW-1:0] rda_reg;
    logic          s1v_reg, s2v_reg;
    logic [AW-1:0] s1a_reg, s2a_reg;

    logic          ld_we;
    logic [AW-1:0] ld_addr;
    logic          ctrl_re, work_re, rd_issue, rd_first, rd_ctrl;
    logic [AW-1:0] rd_addr;
    logic          out_load;

    logic          mv_reg;
    logic [23:0]   mx_reg, my_reg;
    logic          mnp_reg, mdrop_reg;

    logic          in_acc;
    logic [1:0]    cmd;
    logic [16:0]   t_sat;
    logic [15:0]   in_pt   [2];
    logic [W-1:0]  lane_last [2];
    logic [W-1:0]  fin     [2];

    assign in_acc   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign in_pt[0] = s_tdata[15:0];
    assign in_pt[1] = s_tdata[31:16];
    assign t_sat    = (s_tdata[48:32] > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : s_tdata[48:32];
    assign s_tready = (state_reg == bcpe_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        t_next     = t_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        fp_next    = fp_reg;
        emp_next   = emp_reg;
        drop_next  = drop_reg;
        ld_we      = 1'b0;
        ld_addr    = '0;
        ctrl_re    = 1'b0;
        work_re    = 1'b0;
        rd_issue   = 1'b0;
        rd_first   = 1'b0;
        rd_ctrl    = 1'b0;
        rd_addr    = '0;
        out_load   = 1'b0;
        case (state_reg)
            bcpe_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        bcpe_pkg::CMD_START:
                        begin
                            ld_we    = 1'b1;
                            ld_addr  = '0;
                            cnt_next = CW'(1);
                        end
                        bcpe_pkg::CMD_APPEND:
                        begin
                            if (cnt_reg < CW'(MAX_POINTS))
                            begin
                                ld_we    = 1'b1;
                                ld_addr  = cnt_reg[AW-1:0];
                                cnt_next = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        bcpe_pkg::CMD_EVAL:
                        begin
                            t_next    = t_sat;
                            drop_next = ovf_reg;
                            ovf_next  = 1'b0;
                            emp_next  = (cnt_reg == '0);
                            if (cnt_reg == '0)
                            begin
                                state_next = bcpe_pkg::ST_FINISH;
                            end
                            else if (cnt_reg == CW'(1))
                            begin
                                // single point: fetch it and pass it through
                                ctrl_re    = 1'b1;
                                rd_issue   = 1'b1;
                                rd_first   = 1'b1;
                                rd_ctrl    = 1'b1;
                                state_next = bcpe_pkg::ST_SINGLE;
                            end
                            else
                            begin
                                len_next   = cnt_reg;
                                idx_next   = '0;
                                fp_next    = 1'b1;
                                state_next = bcpe_pkg::ST_PASS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bcpe_pkg::ST_PASS:
            begin
                // first pass reads the control store directly
                rd_issue = 1'b1;
                rd_addr  = idx_reg[AW-1:0];
                rd_first = (idx_reg == '0);
                rd_ctrl  = fp_reg;
                ctrl_re  = fp_reg;
                work_re  = !fp_reg;
                if (idx_reg == len_reg - CW'(1))
                begin
                    state_next = bcpe_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            bcpe_pkg::ST_DRAIN:
            begin
                // interlock: all writes of this pass land before the next one reads
                if (!rdv_reg && !s1v_reg && !s2v_reg)
                begin
                    if (len_reg == CW'(2))
                    begin
                        state_next = bcpe_pkg::ST_FINISH;
                    end
                    else
                    begin
                        len_next   = len_reg - CW'(1);
                        idx_next   = '0;
                        fp_next    = 1'b0;
                        state_next = bcpe_pkg::ST_PASS;
                    end
                end
            end
            bcpe_pkg::ST_SINGLE:
            begin
                state_next = bcpe_pkg::ST_FINISH;
            end
            bcpe_pkg::ST_FINISH:
            begin
                if (!mv_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = bcpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcpe_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            len_reg   <= '0;
            idx_reg   <= '0;
            fp_reg    <= 1'b0;
            emp_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
            rd0_reg   <= 1'b0;
            rdc_reg   <= 1'b0;
            rda_reg   <= '0;
            s1v_reg   <= 1'b0;
            s1a_reg   <= '0;
            s2v_reg   <= 1'b0;
            s2a_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            fp_reg    <= fp_next;
            emp_reg   <= emp_next;
            drop_reg  <= drop_next;
            rdv_reg   <= rd_issue;
            rd0_reg   <= rd_first;
            rdc_reg   <= rd_ctrl;
            rda_reg   <= rd_addr;
            s1v_reg   <= rdv_reg && !rd0_reg;
            s1a_reg   <= rda_reg - AW'(1);
            s2v_reg   <= s1v_reg;
            s2a_reg   <= s1a_reg;
            mv_reg    <= out_load ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (out_load)
        begin
            mx_reg    <= emp_reg ? '0 : fin[0][W-1:SH];
            my_reg    <= emp_reg ? '0 : fin[1][W-1:SH];
            mnp_reg   <= emp_reg;
            mdrop_reg <= drop_reg;
        end
    end

    for (genvar g = 0; g < 2; g++)
    begin : g_lane
        logic [15:0]          ctrl_rd;
        logic [W-1:0]         work_rd;
        logic [W-1:0]         cur;
        logic [W-1:0]         lerp;
        logic [W-1:0]         prev_reg;
        logic [W:0]           d_reg;
        logic [W-1:0]         a_reg;
        logic signed [PW-1:0] prod_reg;
        logic signed [PW-1:0] prod_next;
        logic [W-1:0]         a2_reg;
        logic [W-1:0]         last_reg;
        logic [PW-1:0]        rsum;
        logic [W+2:0]         step;
        logic [W+2:0]         lsum;

        bcpe_ram #(
            .WIDTH (16),
            .DEPTH (MAX_POINTS)
        ) u_ctrl_ram (
            .clk   (clk),
            .we    (ld_we),
            .waddr (ld_addr),
            .wdata (in_pt[g]),
            .re    (ctrl_re),
            .raddr (rd_addr),
            .rdata (ctrl_rd)
        );

        bcpe_ram #(
            .WIDTH (W),
            .DEPTH (MAX_POINTS)
        ) u_work_ram (
            .clk   (clk),
            .we    (s2v_reg),
            .waddr (s2a_reg),
            .wdata (lerp),
            .re    (work_re),
            .raddr (rd_addr),
            .rdata (work_rd)
        );

        assign cur       = rdc_reg ? {ctrl_rd, {FRAC_BITS{1'b0}}} : work_rd;
        assign prod_next = $signed(d_reg) * $signed({1'b0, t_reg});
        // round half up, then drop the 16 fraction bits of t
        assign rsum      = prod_reg + PW'(bcpe_pkg::T_HALF);
        assign step      = rsum[PW-1:bcpe_pkg::T_FRAC];
        assign lsum      = {{3{a2_reg[W-1]}}, a2_reg} + step;
        assign lerp      = lsum[W-1:0];

        always_ff @(posedge clk)
        begin
            if (rdv_reg)
            begin
                prev_reg <= cur;
            end
            if (rdv_reg && !rd0_reg)
            begin
                d_reg <= {cur[W-1], cur} - {prev_reg[W-1], prev_reg};
                a_reg <= prev_reg;
            end
            if (s1v_reg)
            begin
                prod_reg <= prod_next;
                a2_reg   <= a_reg;
            end
            if (s2v_reg)
            begin
                last_reg <= lerp;
            end
            else if (state_reg == bcpe_pkg::ST_SINGLE)
            begin
                last_reg <= cur;
            end
        end

        assign lane_last[g] = last_reg;
        assign fin[g]       = lane_last[g] + RND;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {my_reg, mx_reg};
    assign m_tuser  = {mdrop_reg, mnp_reg};

    `BCPE_ASSERT(a_cnt_range, 1'b1, cnt_reg <= CW'(MAX_POINTS), "point count beyond store depth")
    `BCPE_ASSERT(a_wr_in_pass, s2v_reg,
        state_reg == bcpe_pkg::ST_PASS || state_reg == bcpe_pkg::ST_DRAIN,
        "work write outside a pass")
    `BCPE_ASSERT(a_rd_in_len, state_reg == bcpe_pkg::ST_PASS, idx_reg < len_reg,
        "read index past pass length")
    `BCPE_ASSERT(a_empty_zero, m_tvalid && m_tuser[0], m_tdata == '0,
        "empty result with nonzero point")
    `BCPE_ASSERT_NEXT(a_empty_fast,
        in_acc && cmd == bcpe_pkg::CMD_EVAL && cnt_reg == '0,
        state_reg == bcpe_pkg::ST_FINISH, "empty evaluate did not finish at once")

endmodule

// ----- design/bcpe_ram.sv -----
module bcpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_POINTS  = 32;
    localparam int          FRAC_BITS   = 16;
    localparam logic [1:0]  CMD_IGNORED = 2'd3;
    localparam int          ITEMS       = 900;
    localparam int          DRAIN       = 1000;
    localparam longint      LIMIT       = 3_000_000;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               empty;
        logic               dropped;
    } curve_point_t;

    class curve_scoreboard;
        logic signed [15:0] ctrl_x [MAX_POINTS];
        logic signed [15:0] ctrl_y [MAX_POINTS];
        int unsigned        stored;
        bit                 drop_pending;
        curve_point_t       expected_points [$];
        int unsigned        mismatches;
        int unsigned        loads;
        int unsigned        evals;
        int unsigned        empties;
        int unsigned        drops;

        function new();
            stored       = 0;
            drop_pending = 0;
            mismatches   = 0;
            loads        = 0;
            evals        = 0;
            empties      = 0;
            drops        = 0;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // repeated lerps down to one point, then round to q.8
        function logic signed [23:0] casteljau_axis(input logic signed [15:0] pts [MAX_POINTS],
                                                    input longint t);
            longint work [MAX_POINTS];
            longint diff;
            for (int i = 0; i < stored; i++)
                work[i] = longint'(pts[i]) * (longint'(1) << FRAC_BITS);
            for (int len = stored; len > 1; len--)
            begin
                for (int i = 0; i + 1 < len; i++)
                begin
                    diff    = work[i + 1] - work[i];
                    work[i] = work[i] + ((diff * t + longint'(bcpe_pkg::T_HALF))
                                         >>> bcpe_pkg::T_FRAC);
                end
            end
            return 24'((work[0] + (longint'(1) << (FRAC_BITS - bcpe_pkg::OUT_FRAC - 1)))
                       >>> (FRAC_BITS - bcpe_pkg::OUT_FRAC));
        endfunction

        function void note_request(input logic [1:0] cmd, input logic signed [15:0] px,
                                   input logic signed [15:0] py, input logic [16:0] t);
            curve_point_t want;
            longint       tsat;
            case (cmd)
                bcpe_pkg::CMD_START:
                begin
                    ctrl_x[0] = px;
                    ctrl_y[0] = py;
                    stored    = 1;
                    loads++;
                end
                bcpe_pkg::CMD_APPEND:
                begin
                    if (stored < MAX_POINTS)
                    begin
                        ctrl_x[stored] = px;
                        ctrl_y[stored] = py;
                        stored++;
                    end
                    else
                        drop_pending = 1;
                    loads++;
                end
                bcpe_pkg::CMD_EVAL:
                begin
                    tsat = (t > bcpe_pkg::T_ONE) ? longint'(bcpe_pkg::T_ONE) : longint'(t);
                    want.empty   = (stored == 0);
                    want.dropped = drop_pending;
                    want.x       = '0;
                    want.y       = '0;
                    if (stored != 0)
                    begin
                        want.x = casteljau_axis(ctrl_x, tsat);
                        want.y = casteljau_axis(ctrl_y, tsat);
                    end
                    drop_pending = 0;
                    expected_points.push_back(want);
                    evals++;
                    if (want.empty)
                        empties++;
                    if (want.dropped)
                        drops++;
                end
                default:
                begin
                    // ignored command, no state change
                end
            endcase
        endfunction

        function void check_result(input logic [47:0] data, input logic [1:0] user);
            curve_point_t want;
            curve_point_t got;
            got.x       = data[23:0];
            got.y       = data[47:24];
            got.empty   = user[0];
            got.dropped = user[1];
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d no_points=%0b dropped=%0b",
                             got.x, got.y, got.empty, got.dropped);
                return;
            end
            want = expected_points.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected x=%0d y=%0d no_points=%0b dropped=%0b",
                             want.x, want.y, want.empty, want.dropped);
                    $display("          got      x=%0d y=%0d no_points=%0b dropped=%0b",
                             got.x, got.y, got.empty, got.dropped);
                end
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;  // point_x[15:0], point_y[31:16], curve_param[48:32]
    logic [1:0]  s_tuser  = '0;  // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // curve_x[23:0], curve_y[47:24]
    logic [1:0]  m_tuser;        // no_points[0], points_dropped[1]

    curve_scoreboard sb;
    bit              calm       = 1'b0;
    bit              quiet      = 1'b0;
    int unsigned     items_sent = 0;
    int              stall_left = 0;
    longint          cycles     = 0;

    bezier_curve_point_eval #(
        .MAX_POINTS(MAX_POINTS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // result side: check accepted results, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (calm)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return bcpe_pkg::T_ONE;
            2:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic signed [15:0] px,
                                input logic signed [15:0] py, input logic [16:0] t);
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, t, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, px, py, t);
        if (cmd != CMD_IGNORED)
            items_sent++;
    endtask

    // one load, now and then followed by an ignored command or an early evaluate
    task automatic load_point(input logic [1:0] cmd);
        int r;
        send_request(cmd, rand_coord(), rand_coord(), rand_param());
        r = $urandom_range(0, 19);
        if (r == 0)
            send_request(CMD_IGNORED, rand_coord(), rand_coord(), rand_param());
        else if (r == 1)
            send_request(bcpe_pkg::CMD_EVAL, rand_coord(), rand_coord(), rand_param());
    endtask

    task automatic run_random_curve(input bit force_overflow);
        int kind;
        int npts;
        kind  = force_overflow ? 0 : $urandom_range(0, 11);
        quiet = ($urandom_range(0, 3) == 0);
        if (kind == 0)
            npts = MAX_POINTS + $urandom_range(1, 4);
        else if (kind == 1)
            npts = $urandom_range(9, MAX_POINTS);
        else
            npts = $urandom_range(1, 8);
        if (kind == 11)
        begin
            // grow the current curve without a new start
            repeat ($urandom_range(1, 3)) load_point(bcpe_pkg::CMD_APPEND);
        end
        else
        begin
            load_point(bcpe_pkg::CMD_START);
            repeat (npts - 1) load_point(bcpe_pkg::CMD_APPEND);
            if (kind == 0 && (force_overflow || $urandom_range(0, 1) == 1))
            begin
                // a fresh start must keep a pending drop flag
                load_point(bcpe_pkg::CMD_START);
                repeat ($urandom_range(0, 3)) load_point(bcpe_pkg::CMD_APPEND);
            end
        end
        repeat ($urandom_range(1, 4))
            send_request(bcpe_pkg::CMD_EVAL, rand_coord(), rand_coord(), rand_param());
    endtask

    task automatic run_directed();
        // empty store
        send_request(bcpe_pkg::CMD_EVAL, 16'sh1234, -16'sd5, 17'd0);
        send_request(CMD_IGNORED, rand_coord(), rand_coord(), rand_param());
        // append into empty store
        send_request(bcpe_pkg::CMD_APPEND, 16'sh8000, 16'sh7FFF, 17'h1FFFF);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, bcpe_pkg::T_ONE);
        send_request(bcpe_pkg::CMD_START, 16'sh7FFF, 16'sh8000, 17'd0);
        // single point
        send_request(bcpe_pkg::CMD_EVAL, 16'shFFFF, 16'sh0, 17'd0);
        send_request(bcpe_pkg::CMD_APPEND, 16'sh8000, 16'sh7FFF, 17'd0);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, 17'd0);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, bcpe_pkg::T_ONE);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, 17'd32768);
        // saturates to one
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, 17'h1FFFF);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, 17'd65537);
        send_request(bcpe_pkg::CMD_APPEND, -16'sd1, 16'sd1, 17'd0);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, 17'd1);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, 17'd65535);
        send_request(CMD_IGNORED, 16'shFFFF, 16'shFFFF, 17'h1FFFF);
        send_request(bcpe_pkg::CMD_START, 16'sh0, 16'sh0, 17'd0);
        send_request(bcpe_pkg::CMD_APPEND, 16'sh7FFF, 16'sh7FFF, 17'd0);
        send_request(bcpe_pkg::CMD_EVAL, 16'sh0, 16'sh0, rand_param());
    endtask

    initial
    begin : stimulus
        int seq;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        seq = 0;
        while (items_sent < ITEMS)
        begin
            if (!calm && items_sent >= ITEMS * 17 / 20)
                calm <= 1'b1;
            run_random_curve(seq == 0);
            seq++;
        end
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("covered %0d requests in %0d curves: %0d loads, %0d evaluates",
                 items_sent, seq, sb.loads, sb.evals);
        $display("%0d results on an empty store, %0d with dropped points flagged",
                 sb.empties, sb.drops);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
